>>> rtl/core/lz77_scaled_offset_decompressor_core_defines.svh
// ----------------------------------------------------------------------------
// lz77 scaled offset decompressor assertion macros
// Shared concurrent assertion wrappers, clocked on clk, off during arst_n low.
// ----------------------------------------------------------------------------
`ifndef LZ77_SCALED_OFFSET_DECOMPRESSOR_CORE_DEFINES_SVH
`define LZ77_SCALED_OFFSET_DECOMPRESSOR_CORE_DEFINES_SVH

// same-cycle implication check
`define LZSO_ASSERT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication check
`define LZSO_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/core/lzso_pkg.sv
// ----------------------------------------------------------------------------
// lzso_pkg
// Widths and defaults shared by the decompressor core and its channels.
// ----------------------------------------------------------------------------
package lzso_pkg;

	// fixed field widths
	localparam int BYTE_W = 8;
	localparam int POS_W  = 16;

	// parameter defaults
	localparam int HISTORY_DEPTH_DEF = 8192;
	localparam int LEN_BITS_DEF      = 3;
	localparam int OFFSET_BITS_DEF   = 9;

	// block length after reset
	localparam logic [POS_W-1:0] BLOCK_LEN_RESET = 16'd16384;

endpackage

>>> rtl/core/lzso_if.sv
// ----------------------------------------------------------------------------
// lzso channel interfaces
// Valid/ready channels for compressed input beats and decompressed output beats.
// ----------------------------------------------------------------------------

// compressed byte channel
interface lzso_in_if;
	logic                         valid;
	logic                         ready;
	logic [lzso_pkg::BYTE_W-1:0]  comp_byte;

	modport source (output valid, output comp_byte, input ready);
	modport sink   (input valid, input comp_byte, output ready);
endinterface

// decompressed byte channel
interface lzso_out_if;
	logic                         valid;
	logic                         ready;
	logic [lzso_pkg::BYTE_W-1:0]  out_byte;
	logic                         run_last;
	logic                         block_done;
	logic                         bad_reference;

	modport source (output valid, output out_byte, output run_last, output block_done,
		output bad_reference, input ready);
	modport sink   (input valid, input out_byte, input run_last, input block_done,
		input bad_reference, output ready);
endinterface

>>> rtl/core/lz77_scaled_offset_decompressor_core.sv
// ----------------------------------------------------------------------------
// lz77_scaled_offset_decompressor_core
// Block decompressor for an lz77 stream whose offsets are scaled by match length.
// ----------------------------------------------------------------------------
// Usage:
//   comp_in  : one compressed byte per beat, bits read lsb first.
//   dec_out  : one decompressed byte per beat with run_last, block_done and
//              bad_reference marks; run_last tags the last beat of an input.
//   cfg_wr_*: block_length write, only while the core is idle.
// Timing:
//   comp_in.ready is high only while the sequencer is idle; one input beat is
//   worked on at a time. A literal goes through decode, emit and re-check.
//   A reference goes through decode, multiply, one remainder bit per cycle
//   through the shared shift-subtract unit for position mod length, and
//   sum, then a read of the history ram and an emit for each copied byte,
//   since that read is registered; zeros of a bad reference are emitted
//   with no read.
// Reset: clears the bit buffer, output position and output register and
//   loads block_length 16384; history ram contents are not cleared.
// Stall: a result waits in the output register; the sequencer holds in its
//   emit state until that register is free. HISTORY_DEPTH is a power of two.
// ----------------------------------------------------------------------------
`include "lz77_scaled_offset_decompressor_core_defines.svh"

module lz77_scaled_offset_decompressor_core #(
	parameter int HISTORY_DEPTH = lzso_pkg::HISTORY_DEPTH_DEF,
	parameter int LEN_BITS      = lzso_pkg::LEN_BITS_DEF,
	parameter int OFFSET_BITS   = lzso_pkg::OFFSET_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	lzso_in_if.sink                    comp_in,
	lzso_out_if.source                 dec_out,
	input  logic                       cfg_wr_en,
	input  logic [lzso_pkg::POS_W-1:0] cfg_wr_data
);

	localparam int BYTE_W = lzso_pkg::BYTE_W;
	localparam int POS_W  = lzso_pkg::POS_W;
	localparam int TOK_W  = 1 + LEN_BITS + OFFSET_BITS;
	localparam int LIT_W  = 1 + BYTE_W;
	localparam int MAXT_W = (TOK_W > LIT_W) ? TOK_W : LIT_W;
	localparam int ACC_W  = MAXT_W + BYTE_W - 1;
	localparam int CNT_W  = $clog2(ACC_W + 1);
	localparam int LEN_W  = $clog2((1 << LEN_BITS) + 2);
	localparam int OFF_W  = OFFSET_BITS + 1;
	localparam int PROD_W = LEN_W + OFF_W;
	localparam int DIST_W = ((PROD_W > POS_W) ? PROD_W : POS_W) + 1;
	localparam int DCNT_W = $clog2(POS_W + 1);
	localparam int ADDR_W = $clog2(HISTORY_DEPTH);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DECODE = 7'b0000010,
		ST_MULT   = 7'b0000100,
		ST_DIV    = 7'b0001000,
		ST_SUM    = 7'b0010000,
		ST_READ   = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

	state_t                 state_q, state_d;
	logic [ACC_W-1:0]       acc_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [POS_W-1:0]       pos_q;
	logic [POS_W-1:0]       block_len_q;
	logic [DCNT_W-1:0]      dcnt_q;
	logic                   out_valid_q;

	logic [BYTE_W-1:0]      lit_q;
	logic [LEN_W-1:0]       len_q;
	logic [OFF_W-1:0]       off_q;
	logic [PROD_W-1:0]      prod_q;
	logic [POS_W-1:0]       x_sh_q;
	logic [LEN_W-1:0]       rem_q;
	logic [ADDR_W-1:0]      ptr_q;
	logic                   bad_q;
	logic                   tok_lit_q;
	logic [LEN_W-1:0]       rem_bytes_q;
	logic [BYTE_W-1:0]      rd_q;
	logic [BYTE_W-1:0]      out_byte_q;
	logic                   out_last_q;
	logic                   out_done_q;
	logic                   out_bad_q;

	logic [BYTE_W-1:0]      ring_q [HISTORY_DEPTH];

	logic                   in_fire;
	logic [CNT_W-1:0]       need;
	logic                   tok_rdy;
	logic [LEN_W:0]         trial;
	logic                   trial_ge;
	logic [DIST_W-1:0]      ref_dist;
	logic [DIST_W-1:0]      x_ext;
	logic [DIST_W-1:0]      src;
	logic                   ref_bad;
	logic                   emit_fire;
	logic [BYTE_W-1:0]      emit_byte;
	logic                   emit_last_tok;
	logic                   emit_done;
	logic [POS_W:0]         limit;

	// handshake outputs
	assign comp_in.ready         = (state_q == ST_IDLE);
	assign in_fire               = comp_in.valid && comp_in.ready;
	assign dec_out.valid         = out_valid_q;
	assign dec_out.out_byte      = out_byte_q;
	assign dec_out.run_last      = out_last_q;
	assign dec_out.block_done    = out_done_q;
	assign dec_out.bad_reference = out_bad_q;

	// token availability in the bit buffer
	assign need    = acc_q[0] ? CNT_W'(TOK_W) : CNT_W'(LIT_W);
	assign tok_rdy = (cnt_q != '0) && (cnt_q >= need);

	// shared shift-subtract step for position mod length
	assign trial    = {rem_q, x_sh_q[POS_W-1]};
	assign trial_ge = (trial >= {1'b0, len_q});

	// source distance and bad reference check
	assign ref_dist = DIST_W'(prod_q) + DIST_W'(rem_q);
	assign x_ext    = DIST_W'(pos_q);
	assign ref_bad  = (ref_dist > x_ext);
	assign src      = x_ext - ref_dist;

	// byte emission
	assign emit_fire     = (state_q == ST_EMIT) && (!out_valid_q || dec_out.ready);
	assign emit_byte     = bad_q ? '0 : (tok_lit_q ? lit_q : rd_q);
	assign emit_last_tok = (rem_bytes_q == LEN_W'(1));
	assign limit         = (block_len_q == '0) ? {1'b1, {POS_W{1'b0}}} : {1'b0, block_len_q};
	assign emit_done     = (({1'b0, pos_q} + (POS_W+1)'(1)) >= limit);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (!tok_rdy) state_d = ST_IDLE;
				else if (acc_q[0]) state_d = ST_MULT;
				else state_d = ST_EMIT;
			end
			ST_MULT: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (dcnt_q == DCNT_W'(1)) state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d = ref_bad ? ST_EMIT : ST_READ;
			end
			ST_READ: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_fire) begin
					if (emit_done) state_d = ST_IDLE;
					else if (emit_last_tok) state_d = ST_DECODE;
					else if (!bad_q) state_d = ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			cnt_q       <= '0;
			pos_q       <= '0;
			block_len_q <= lzso_pkg::BLOCK_LEN_RESET;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) block_len_q <= cfg_wr_data;

			// bit buffer fill and token consumption
			if (in_fire) begin
				acc_q <= acc_q | ({{(ACC_W-BYTE_W){1'b0}}, comp_in.comp_byte} << cnt_q);
				cnt_q <= cnt_q + CNT_W'(BYTE_W);
			end else if (state_q == ST_DECODE && tok_rdy) begin
				if (acc_q[0]) begin
					acc_q <= acc_q >> TOK_W;
					cnt_q <= cnt_q - CNT_W'(TOK_W);
				end else begin
					acc_q <= acc_q >> LIT_W;
					cnt_q <= cnt_q - CNT_W'(LIT_W);
				end
			end else if (emit_fire && emit_done) begin
				acc_q <= '0;
				cnt_q <= '0;
			end

			// output position
			if (emit_fire) pos_q <= emit_done ? '0 : pos_q + POS_W'(1);

			// remainder iteration count
			if (state_q == ST_MULT) dcnt_q <= DCNT_W'(POS_W);
			else if (state_q == ST_DIV) dcnt_q <= dcnt_q - DCNT_W'(1);

			// output register
			if (emit_fire) out_valid_q <= 1'b1;
			else if (dec_out.ready) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_DECODE: begin
				lit_q       <= acc_q[BYTE_W:1];
				len_q       <= LEN_W'(acc_q[LEN_BITS:1]) + LEN_W'(2);
				off_q       <= OFF_W'(acc_q[TOK_W-1:LEN_BITS+1]) + OFF_W'(1);
				tok_lit_q   <= 1'b1;
				bad_q       <= 1'b0;
				rem_bytes_q <= LEN_W'(1);
			end
			ST_MULT: begin
				prod_q <= PROD_W'(len_q) * PROD_W'(off_q);
				x_sh_q <= pos_q;
				rem_q  <= '0;
			end
			ST_DIV: begin
				rem_q  <= trial_ge ? LEN_W'(trial - {1'b0, len_q}) : LEN_W'(trial);
				x_sh_q <= x_sh_q << 1;
			end
			ST_SUM: begin
				ptr_q       <= src[ADDR_W-1:0];
				bad_q       <= ref_bad;
				tok_lit_q   <= 1'b0;
				rem_bytes_q <= len_q;
			end
			ST_EMIT: begin
				if (emit_fire && !emit_last_tok) begin
					ptr_q       <= ptr_q + ADDR_W'(1);
					rem_bytes_q <= rem_bytes_q - LEN_W'(1);
				end
			end
			default: begin
			end
		endcase

		if (emit_fire) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_done || (emit_last_tok && !tok_rdy);
			out_done_q <= emit_done;
			out_bad_q  <= bad_q;
		end
	end

	// history ram, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (emit_fire) ring_q[pos_q[ADDR_W-1:0]] <= emit_byte;
		if (state_q == ST_READ) rd_q <= ring_q[ptr_q];
	end

	// checks
	`LZSO_ASSERT(a_bad_is_zero, out_valid_q && out_bad_q, out_byte_q == '0, "bad reference beat carries a nonzero byte")
	`LZSO_ASSERT_NEXT(a_block_end_clears, emit_fire && emit_done, pos_q == '0 && cnt_q == '0 && state_q == ST_IDLE, "block end did not clear decoder state")
	`LZSO_ASSERT(a_rem_below_len, state_q == ST_SUM, rem_q < len_q, "remainder not below match length")
	`LZSO_ASSERT(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(ACC_W), "bit count exceeds buffer width")

endmodule

>>> bench/lz77_scaled_offset_decompressor_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77 scaled offset decompressor core test
// Feeds compressed beats built from literal and reference tokens, plus raw
// noise, through several block lengths. A scoreboard decodes every accepted
// beat on its own and checks each decompressed beat field by field.
// ----------------------------------------------------------------------------
module lz77_scaled_offset_decompressor_core_test;

	localparam int BYTE_W        = lzso_pkg::BYTE_W;
	localparam int POS_W         = lzso_pkg::POS_W;
	localparam int HIST          = lzso_pkg::HISTORY_DEPTH_DEF;
	localparam int LEN_W         = lzso_pkg::LEN_BITS_DEF;
	localparam int OFF_W         = lzso_pkg::OFFSET_BITS_DEF;
	localparam int TOKEN_BITS    = 1 + LEN_W + OFF_W;
	localparam int LITERAL_BITS  = 1 + BYTE_W;
	localparam int ACC_W         = 20;
	localparam int SETTLE_CYCLES = 64;
	localparam int ITEMS_TARGET  = 200;
	localparam int HOLD_CYCLES   = 600;
	localparam int CYCLE_LIMIT   = 500000;

	// one decompressed beat
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              run_last;
		logic              block_done;
		logic              bad_reference;
	} dec_beat_t;

	// decoder state mirror and queue of decompressed beats still to come
	class decode_scoreboard;
		logic [ACC_W-1:0]  acc;
		logic [4:0]        cnt;
		logic [POS_W-1:0]  pos;
		logic [POS_W-1:0]  blen;
		logic [BYTE_W-1:0] ring [HIST];
		dec_beat_t         expected [$];
		int                failures;

		function new();
			acc = '0;
			cnt = '0;
			pos = '0;
			blen = lzso_pkg::BLOCK_LEN_RESET;
			failures = 0;
			foreach (ring[i]) ring[i] = '0;
		endfunction

		function void set_length(logic [POS_W-1:0] v);
			blen = v;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function void drop_bits(int n);
			acc = acc >> n;
			cnt = cnt - 5'(n);
		endfunction

		// produce one byte, returns 1 when it closes the block
		function bit emit_byte(logic [BYTE_W-1:0] v, bit bad);
			int        limit;
			bit        done;
			dec_beat_t beat;
			limit = (blen == 0) ? 65536 : int'(blen);
			done = (int'(pos) + 1) >= limit;
			ring[int'(pos) % HIST] = v;
			beat.out_byte = v;
			beat.run_last = 1'b0;
			beat.block_done = done;
			beat.bad_reference = bad;
			expected.push_back(beat);
			if (done) begin
				acc = '0;
				cnt = '0;
				pos = '0;
			end else begin
				pos = pos + 1'b1;
			end
			return done;
		endfunction

		// decode every complete token the new beat makes available
		function void note_input(logic [BYTE_W-1:0] b);
			int                mark;
			int                need;
			int                len;
			int                off;
			int                x;
			int                ref_dist;
			bit                ended;
			logic [BYTE_W-1:0] lit;
			mark = expected.size();
			acc = acc | (ACC_W'(b) << cnt);
			cnt = cnt + 5'd8;
			ended = 1'b0;
			while (!ended && cnt != 0) begin
				need = acc[0] ? TOKEN_BITS : LITERAL_BITS;
				if (int'(cnt) < need)
					break;
				if (!acc[0]) begin
					lit = acc[BYTE_W:1];
					drop_bits(LITERAL_BITS);
					ended = emit_byte(lit, 1'b0);
				end else begin
					len = int'((acc >> 1) & ((1 << LEN_W) - 1)) + 2;
					off = int'((acc >> (1 + LEN_W)) & ((1 << OFF_W) - 1)) + 1;
					drop_bits(TOKEN_BITS);
					x = int'(pos);
					ref_dist = len * off + x % len;
					// source before block start gives flagged zeros
					for (int i = 0; i < len && !ended; i++) begin
						if (ref_dist > x)
							ended = emit_byte('0, 1'b1);
						else
							ended = emit_byte(ring[(x - ref_dist + i) % HIST], 1'b0);
					end
				end
			end
			if (expected.size() > mark)
				expected[expected.size() - 1].run_last = 1'b1;
		endfunction

		function void check_result(dec_beat_t got);
			dec_beat_t want;
			if (expected.size() == 0) begin
				$error("output beat %0h arrived with nothing expected", got.out_byte);
				failures++;
				return;
			end
			want = expected.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
				failures++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
				failures++;
			end
			if (got.block_done !== want.block_done) begin
				$error("block_done: expected %0b, got %0b", want.block_done, got.block_done);
				failures++;
			end
			if (got.bad_reference !== want.bad_reference) begin
				$error("bad_reference: expected %0b, got %0b", want.bad_reference,
					got.bad_reference);
				failures++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [POS_W-1:0] cfg_wr_data;

	lzso_in_if  comp_in();
	lzso_out_if dec_out();

	lz77_scaled_offset_decompressor_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.comp_in     (comp_in),
		.dec_out     (dec_out),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	decode_scoreboard sb = new();

	// stream encoder state: unsent bits, block position and limit it assumes
	bit tx_bits [$];
	int tx_pos;
	int tx_limit;

	int  burst_left = 0;
	int  items_sent = 0;
	int  cycle_count = 0;
	bit  hold_armed = 1'b0;
	int  rx_cycle = 0;
	int  rx_hold = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// accepted beats on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (comp_in.valid && comp_in.ready)
				sb.note_input(comp_in.comp_byte);
			if (dec_out.valid && dec_out.ready)
				sb.check_result('{dec_out.out_byte, dec_out.run_last, dec_out.block_done,
					dec_out.bad_reference});
		end
	end

	// output stall pattern, with one long hold-off on request
	initial begin
		dec_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_armed) begin
				hold_armed = 1'b0;
				rx_hold = HOLD_CYCLES;
			end
			if (rx_hold != 0) begin
				dec_out.ready <= 1'b0;
				rx_hold--;
			end else begin
				case ((rx_cycle / 97) % 4)
					0: dec_out.ready <= 1'b1;
					1: dec_out.ready <= 1'($urandom_range(0, 1));
					2: dec_out.ready <= ($urandom_range(0, 4) == 0);
					default: dec_out.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
			rx_cycle++;
		end
	end

	function automatic void push_bits(int v, int n);
		for (int i = 0; i < n; i++)
			tx_bits.push_back(1'((v >> i) & 1));
	endfunction

	// step the block position; at block end the rest of the byte is filler
	function automatic void advance(int n);
		for (int i = 0; i < n; i++) begin
			if (tx_pos + 1 >= tx_limit) begin
				tx_pos = 0;
				while (tx_bits.size() % 8 != 0)
					tx_bits.push_back(1'($urandom_range(0, 1)));
				return;
			end
			tx_pos++;
		end
	endfunction

	function automatic void put_literal(int v);
		push_bits(0, 1);
		push_bits(v, BYTE_W);
		advance(1);
	endfunction

	function automatic void put_reference(int len_code, int off_code);
		push_bits(1, 1);
		push_bits(len_code, LEN_W);
		push_bits(off_code, OFF_W);
		advance(len_code + 2);
	endfunction

	// mostly references that land inside the block, some that do not
	function automatic void put_random_token();
		int len_code;
		int room;
		if ($urandom_range(0, 99) < 40) begin
			put_literal($urandom_range(0, 255));
			return;
		end
		len_code = $urandom_range(0, (1 << LEN_W) - 1);
		room = tx_pos / (len_code + 2);
		if (room > (1 << OFF_W))
			room = 1 << OFF_W;
		if (room == 0 || $urandom_range(0, 9) == 0)
			put_reference(len_code, $urandom_range(0, (1 << OFF_W) - 1));
		else if ($urandom_range(0, 4) == 0)
			put_reference(len_code, room - 1);
		else
			put_reference(len_code, $urandom_range(0, room - 1));
	endfunction

	// realign the encoder with the decoder while idle, finishing a partial token
	function automatic void resync();
		int need;
		int rest;
		int fill;
		int token;
		tx_bits.delete();
		tx_pos = int'(sb.pos);
		tx_limit = (sb.blen == 0) ? 65536 : int'(sb.blen);
		if (sb.cnt != 0) begin
			need = sb.acc[0] ? TOKEN_BITS : LITERAL_BITS;
			rest = need - int'(sb.cnt);
			fill = $urandom_range(0, (1 << rest) - 1);
			push_bits(fill, rest);
			token = int'(sb.acc) | (fill << int'(sb.cnt));
			if (sb.acc[0])
				advance(((token >> 1) & ((1 << LEN_W) - 1)) + 2);
			else
				advance(1);
		end
	endfunction

	function automatic logic [BYTE_W-1:0] next_stream_byte();
		logic [BYTE_W-1:0] b;
		while (tx_bits.size() < BYTE_W)
			put_random_token();
		for (int i = 0; i < BYTE_W; i++)
			b[i] = tx_bits.pop_front();
		return b;
	endfunction

	function automatic logic [POS_W-1:0] pick_length();
		case ($urandom_range(0, 9))
			0, 1, 2: return POS_W'($urandom_range(1, 8));
			3, 4, 5, 6: return POS_W'($urandom_range(9, 200));
			7: return '1;
			8: return '0;
			default: return POS_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// one input beat, sent in bursts with random gaps between them
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				comp_in.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		comp_in.valid <= 1'b1;
		comp_in.comp_byte <= b;
		do @(posedge clk); while (!comp_in.ready);
		burst_left--;
	endtask

	// drain all expected beats, then let a no-output beat finish
	task automatic wait_idle();
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_block_length(input logic [POS_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_length(v);
	endtask

	task automatic run_phase(input int n_items, input bit noisy);
		resync();
		for (int i = 0; i < n_items; i++) begin
			if (noisy)
				send_byte(BYTE_W'($urandom_range(0, 255)));
			else
				send_byte(next_stream_byte());
			items_sent++;
		end
		comp_in.valid <= 1'b0;
		wait_idle();
	endtask

	// literals at both extremes, good and bad references, then raw all-ones/zeros
	task automatic run_directed();
		logic [BYTE_W-1:0] raw [4] = '{8'hFF, 8'hFF, 8'h00, 8'h00};
		logic [BYTE_W-1:0] b;
		resync();
		put_literal(8'h00);
		put_literal(8'hFF);
		put_literal(8'h5A);
		put_reference(0, 0);
		put_reference((1 << LEN_W) - 1, 0);
		put_reference(1, 1);
		put_reference((1 << LEN_W) - 1, 0);
		while (tx_bits.size() >= BYTE_W) begin
			for (int i = 0; i < BYTE_W; i++)
				b[i] = tx_bits.pop_front();
			send_byte(b);
		end
		foreach (raw[i])
			send_byte(raw[i]);
		comp_in.valid <= 1'b0;
		wait_idle();
	endtask

	initial begin
		logic [POS_W-1:0] fixed_lengths [5];
		int               phase_no;
		fixed_lengths = '{16'd1, 16'd0, 16'hFFFF, 16'd2, 16'd7};
		arst_n <= 1'b0;
		comp_in.valid <= 1'b0;
		comp_in.comp_byte <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// random phases, each under its own block length
		phase_no = 0;
		while (items_sent < ITEMS_TARGET) begin
			if (phase_no < 5)
				write_block_length(fixed_lengths[phase_no]);
			else
				write_block_length(pick_length());
			if (phase_no == 3)
				hold_armed = 1'b1;
			run_phase($urandom_range(8, 24), $urandom_range(0, 6) == 0);
			phase_no++;
		end

		if (sb.failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
